// ===== rtl/brst_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers of the block request slot tracker
package brst_pkg;

  localparam int REQUEST_SLOTS  = 8;
  localparam int SECTOR_BYTES   = 512;
  localparam int MAX_IO_SECTORS = 8;

  localparam int GEN_W   = 32;
  localparam int SLOT_W  = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_IO_SECTORS + 1);
  localparam int BYTES_W = 9 + $clog2(SECTOR_BYTES + 1);
  localparam int ADDR_W  = 4;

  typedef enum logic [2:0] {
    OP_SUBMIT       = 3'd0,
    OP_COMPLETE_ONE = 3'd1,
    OP_COMPLETE_ALL = 3'd2,
    OP_COLLECT      = 3'd3,
    OP_REVOKE       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_PENDING = 2'd1,
    SLOT_DONE    = 2'd2,
    SLOT_ERROR   = 2'd3
  } slot_status_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_EXEC
  } eng_state_t;

  localparam logic [1:0] REG_CAPACITY  = 2'd0;
  localparam logic [1:0] REG_READ_ONLY = 2'd1;
  localparam logic [1:0] REG_DEFER     = 2'd2;

  typedef struct packed {
    logic [31:0] capacity;
    logic        read_only;
    logic        defer;
  } cfg_t;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic             is_write;
    logic [CNT_W-1:0] count;
  } slot_meta_t;

  localparam slot_meta_t RESET_META = '{gen: GEN_W'(1), is_write: 1'b0, count: '0};

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_meta_t        wdata;
  } ram_req_t;

  function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
    next_gen = (g == '1) ? GEN_W'(1) : g + GEN_W'(1);
  endfunction

endpackage

// ===== rtl/brst_ifs.sv =====
`timescale 1ns / 1ps
// command and response channel interfaces
interface brst_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic        write;
  logic [31:0] lba;
  logic [8:0]  sectors;
  logic [17:0] buffer_bytes;
  logic [7:0]  handle_index;
  logic [31:0] handle_generation;
  logic        completion_error;

  modport source (
    output valid, operation, write, lba, sectors, buffer_bytes, handle_index,
           handle_generation, completion_error,
    input  ready
  );
  modport sink (
    input  valid, operation, write, lba, sectors, buffer_bytes, handle_index,
           handle_generation, completion_error,
    output ready
  );
endinterface

interface brst_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [6:0]  issued_index;
  logic [31:0] issued_generation;
  logic        result_status;
  logic [17:0] transferred_bytes;

  modport source (
    output valid, accepted, issued_index, issued_generation, result_status,
           transferred_bytes,
    input  ready
  );
  modport sink (
    input  valid, accepted, issued_index, issued_generation, result_status,
           transferred_bytes,
    output ready
  );
endinterface

// ===== rtl/brst_cfg_regs.sv =====
`timescale 1ns / 1ps
// apb configuration registers
module brst_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [brst_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output brst_pkg::cfg_t            cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity  <= 32'd1;
      cfg.read_only <= 1'b0;
      cfg.defer     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        brst_pkg::REG_CAPACITY:  cfg.capacity  <= pwdata;
        brst_pkg::REG_READ_ONLY: cfg.read_only <= pwdata[0];
        brst_pkg::REG_DEFER:     cfg.defer     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      brst_pkg::REG_CAPACITY:  prdata = cfg.capacity;
      brst_pkg::REG_READ_ONLY: prdata = {31'd0, cfg.read_only};
      brst_pkg::REG_DEFER:     prdata = {31'd0, cfg.defer};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/brst_slot_ram.sv =====
`timescale 1ns / 1ps
// slot generation and request memory with written flags
module brst_slot_ram (
  input  logic                 clk,
  input  logic                 rst,
  input  brst_pkg::ram_req_t   req,
  output brst_pkg::slot_meta_t rdata
);

  brst_pkg::slot_meta_t mem [brst_pkg::REQUEST_SLOTS];
  logic [brst_pkg::REQUEST_SLOTS-1:0] written;
  brst_pkg::slot_meta_t mem_q;
  logic hit_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      mem_q <= mem[req.raddr];
      hit_q <= written[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

  // never written entries read as their reset contents
  assign rdata = hit_q ? mem_q : brst_pkg::RESET_META;

endmodule

// ===== rtl/brst_engine.sv =====
`timescale 1ns / 1ps
// command sequencer, slot status table and response register
module brst_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  brst_pkg::cfg_t       cfg,
  brst_cmd_if.sink             cmd,
  brst_rsp_if.source           rsp,
  output brst_pkg::ram_req_t   ram_req,
  input  brst_pkg::slot_meta_t ram_rdata
);

  localparam int SW = brst_pkg::SLOT_W;
  localparam int BW = brst_pkg::BYTES_W;

  brst_pkg::eng_state_t   state, state_next;
  brst_pkg::slot_status_t status [brst_pkg::REQUEST_SLOTS];
  brst_pkg::slot_status_t status_next [brst_pkg::REQUEST_SLOTS];
  logic revoked, revoked_next;

  // latched item
  logic [2:0]   op_q;
  logic         wr_q;
  logic [31:0]  lba_q;
  logic [8:0]   sec_q;
  logic [17:0]  len_q;
  logic [7:0]   hidx_q;
  logic [31:0]  hgen_q;
  logic         cerr_q;
  logic [SW-1:0] slot_q;
  logic         free_q;

  // response register
  logic        rsp_valid;
  logic        out_acc, out_acc_next;
  logic [6:0]  out_idx, out_idx_next;
  logic [31:0] out_gen, out_gen_next;
  logic        out_stat, out_stat_next;
  logic [17:0] out_bytes, out_bytes_next;

  logic          fire, out_free, exec_go, mem_we;
  logic          free_any;
  logic [SW-1:0] free_idx, coll_idx, one_idx;
  logic          coll_range, one_range;
  brst_pkg::slot_meta_t wdata;

  logic          submit_ok, collect_ok;
  logic [BW-1:0] sub_bytes, coll_bytes;
  brst_pkg::slot_status_t coll_st;

  assign fire     = cmd.valid && cmd.ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign exec_go  = (state == brst_pkg::ENG_EXEC) && out_free;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int s = brst_pkg::REQUEST_SLOTS - 1; s >= 0; s--) begin
      if (status[s] == brst_pkg::SLOT_FREE) begin
        free_any = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  assign coll_range = (cmd.handle_index != 8'd0) &&
                      (cmd.handle_index <= 8'(brst_pkg::REQUEST_SLOTS));
  assign coll_idx   = coll_range ? SW'(cmd.handle_index - 8'd1) : '0;
  assign one_range  = hidx_q < 8'(brst_pkg::REQUEST_SLOTS);
  assign one_idx    = one_range ? SW'(hidx_q) : '0;

  always_comb begin
    unique case (state)
      brst_pkg::ENG_IDLE: state_next = fire ? brst_pkg::ENG_EXEC : brst_pkg::ENG_IDLE;
      brst_pkg::ENG_EXEC: state_next = out_free ? brst_pkg::ENG_IDLE : brst_pkg::ENG_EXEC;
      default:            state_next = brst_pkg::ENG_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready     = (state == brst_pkg::ENG_IDLE);
    ram_req.re    = fire;
    ram_req.raddr = (cmd.operation == brst_pkg::OP_SUBMIT) ? free_idx : coll_idx;
    ram_req.we    = exec_go && mem_we;
    ram_req.waddr = slot_q;
    ram_req.wdata = wdata;
  end

  // submit and collect checks
  assign sub_bytes  = BW'(sec_q) * BW'(brst_pkg::SECTOR_BYTES);
  assign coll_bytes = BW'(ram_rdata.count) * BW'(brst_pkg::SECTOR_BYTES);
  assign coll_st    = status[slot_q];

  assign submit_ok = !revoked && free_q && (sec_q != 9'd0) &&
                     (sec_q <= 9'(brst_pkg::MAX_IO_SECTORS)) &&
                     (lba_q < cfg.capacity) &&
                     (({1'b0, lba_q} + 33'(sec_q)) <= {1'b0, cfg.capacity}) &&
                     (BW'(len_q) == sub_bytes) &&
                     !(wr_q && cfg.read_only);

  assign collect_ok = (hidx_q != 8'd0) && (hidx_q <= 8'(brst_pkg::REQUEST_SLOTS)) &&
                      (hgen_q != 32'd0) && (ram_rdata.gen == hgen_q) &&
                      ((coll_st == brst_pkg::SLOT_DONE) ||
                       (coll_st == brst_pkg::SLOT_ERROR)) &&
                      !((coll_st == brst_pkg::SLOT_DONE) && !ram_rdata.is_write &&
                        (BW'(len_q) < coll_bytes));

  always_comb begin
    status_next    = status;
    revoked_next   = revoked;
    out_acc_next   = 1'b0;
    out_idx_next   = 7'd0;
    out_gen_next   = 32'd0;
    out_stat_next  = 1'b0;
    out_bytes_next = 18'd0;
    mem_we         = 1'b0;
    wdata          = ram_rdata;
    case (op_q)
      brst_pkg::OP_SUBMIT: begin
        if (submit_ok) begin
          out_acc_next        = 1'b1;
          out_idx_next        = 7'(slot_q) + 7'd1;
          out_gen_next        = ram_rdata.gen;
          status_next[slot_q] = cfg.defer ? brst_pkg::SLOT_PENDING : brst_pkg::SLOT_DONE;
          mem_we              = 1'b1;
          wdata.is_write      = wr_q;
          wdata.count         = sec_q[brst_pkg::CNT_W-1:0];
        end
      end
      brst_pkg::OP_COMPLETE_ONE: begin
        if (!revoked && one_range && (status[one_idx] == brst_pkg::SLOT_PENDING)) begin
          out_acc_next         = 1'b1;
          status_next[one_idx] = cerr_q ? brst_pkg::SLOT_ERROR : brst_pkg::SLOT_DONE;
        end
      end
      brst_pkg::OP_COMPLETE_ALL: begin
        if (!revoked) begin
          for (int s = 0; s < brst_pkg::REQUEST_SLOTS; s++) begin
            if (status[s] == brst_pkg::SLOT_PENDING) begin
              status_next[s] = brst_pkg::SLOT_DONE;
              out_acc_next   = 1'b1;
            end
          end
        end
      end
      brst_pkg::OP_COLLECT: begin
        if (collect_ok) begin
          out_acc_next        = 1'b1;
          out_stat_next       = (coll_st == brst_pkg::SLOT_ERROR);
          out_bytes_next      = (coll_st == brst_pkg::SLOT_DONE) ? coll_bytes[17:0] : 18'd0;
          status_next[slot_q] = brst_pkg::SLOT_FREE;
          mem_we              = 1'b1;
          wdata.gen           = brst_pkg::next_gen(ram_rdata.gen);
        end
      end
      brst_pkg::OP_REVOKE: begin
        // freed slots stay unreachable, so their generations need no update
        if (!revoked) begin
          revoked_next = 1'b1;
          out_acc_next = 1'b1;
          for (int s = 0; s < brst_pkg::REQUEST_SLOTS; s++) begin
            status_next[s] = brst_pkg::SLOT_FREE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brst_pkg::ENG_IDLE;
      revoked   <= 1'b0;
      rsp_valid <= 1'b0;
      for (int s = 0; s < brst_pkg::REQUEST_SLOTS; s++) begin
        status[s] <= brst_pkg::SLOT_FREE;
      end
    end else begin
      state <= state_next;
      if (exec_go) begin
        revoked <= revoked_next;
        status  <= status_next;
      end
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      op_q   <= cmd.operation;
      wr_q   <= cmd.write;
      lba_q  <= cmd.lba;
      sec_q  <= cmd.sectors;
      len_q  <= cmd.buffer_bytes;
      hidx_q <= cmd.handle_index;
      hgen_q <= cmd.handle_generation;
      cerr_q <= cmd.completion_error;
      slot_q <= ram_req.raddr;
      free_q <= free_any;
    end
    if (exec_go) begin
      out_acc   <= out_acc_next;
      out_idx   <= out_idx_next;
      out_gen   <= out_gen_next;
      out_stat  <= out_stat_next;
      out_bytes <= out_bytes_next;
    end
  end

  assign rsp.valid             = rsp_valid;
  assign rsp.accepted          = out_acc;
  assign rsp.issued_index      = out_idx;
  assign rsp.issued_generation = out_gen;
  assign rsp.result_status     = out_stat;
  assign rsp.transferred_bytes = out_bytes;

endmodule

// ===== rtl/block_request_slot_tracker.sv =====
`timescale 1ns / 1ps
// top level of the block request slot tracker
//
// cmd carries one item per operation: submit, complete one, complete all,
// collect or revoke. rsp returns exactly one item for every cmd item, in order.
// configuration (capacity, read-only, deferred completion) is written over the
// apb port; the user must do so only while the block is idle, as the block
// itself does not enforce it; pready is always high. the accept cycle picks
// the slot (lowest free slot for submit, handle slot for collect) and reads
// its generation and request data from the slot memory; the exec state then
// checks the item, writes the slot back and loads the response register. one
// item is in work at a time, because of the read-modify-write of the slot
// memory, which has no forwarding. slot status is held in flip-flops.
// the response register holds a result until rsp.ready; while it is full the
// finished item waits in the exec state and cmd.ready stays low.
// synchronous reset frees every slot, sets every generation to one, clears the
// revoke flag and the response valid flag, and restores the register defaults.
module block_request_slot_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brst_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  brst_cmd_if.sink                    cmd,
  brst_rsp_if.source                  rsp
);

  brst_pkg::cfg_t       cfg;
  brst_pkg::ram_req_t   ram_req;
  brst_pkg::slot_meta_t ram_rdata;

  brst_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brst_slot_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  brst_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .rsp       (rsp),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule

// ===== rtl/brst_checker.sv =====
`timescale 1ns / 1ps
// port-level assertions for the block request slot tracker
module brst_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_accepted,
  input logic [6:0]  rsp_issued_index,
  input logic        rsp_result_status,
  input logic [17:0] rsp_transferred_bytes
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second item taken while one is in work");

  a_index_accepted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_issued_index != 7'd0) |-> rsp_accepted)
    else $error("slot issued on a rejected item");

  a_bytes_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_transferred_bytes != 18'd0) |-> rsp_accepted && !rsp_result_status)
    else $error("bytes reported on a failed or rejected item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response pending after reset");

endmodule

bind block_request_slot_tracker brst_checker u_brst_checker (
  .clk                   (clk),
  .rst                   (rst),
  .cmd_valid             (cmd.valid),
  .cmd_ready             (cmd.ready),
  .rsp_valid             (rsp.valid),
  .rsp_ready             (rsp.ready),
  .rsp_accepted          (rsp.accepted),
  .rsp_issued_index      (rsp.issued_index),
  .rsp_result_status     (rsp.result_status),
  .rsp_transferred_bytes (rsp.transferred_bytes)
);
